// ===== src/i2cbm_pkg.sv =====
package i2cbm_pkg;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } cmd_t;

    localparam int unsigned TICK_W = 16;
    localparam logic [TICK_W-1:0] PHASE_TICKS_RESET = 16'd20;

    // for a data or ACK bit, phase 0: SCL low with new SDA, phase 1: SCL high (sample), phase 2: SCL low
    localparam logic [1:0] PHASE_SETUP  = 2'd0;
    localparam logic [1:0] PHASE_SAMPLE = 2'd1;
    localparam logic [1:0] PHASE_HOLD   = 2'd2;

    // bit counter value of the ACK slot after the eight data bits
    localparam logic [3:0] BIT_ACK = 4'd8;

    typedef struct packed {
        logic scl;
        logic sda;
    } lines_t;

endpackage

// ===== src/i2c_byte_master.sv =====
// Byte-level I2C master. Every input word is one tick of the bus phase timer:
// s_tuser carries the command (0 none, 1 start, 2 stop, 3 write byte, 4 read byte),
// taken only while no command runs, and s_tdata carries the byte to write, the
// ACK/NACK choice for a read and the sampled SDA level. Every accepted word gives
// exactly one result word with the SCL and SDA drive levels after that tick
// (SDA 1 means released), busy, a done pulse on the finishing tick, the ACK bit
// seen by the last write and the byte assembled by the last read. Each bus phase
// lasts phase_ticks ticks after the tick that opens it; a data or ACK bit takes
// three phases, so a byte command runs 27 phases and start/stop three. The block
// takes one word per cycle: all the work of a tick is one short pass from the
// state registers to the result register, and s_tready falls only while a
// result waits and the sink holds m_tready low. Write phase_ticks only while
// idle; zero behaves as one.
module i2c_byte_master (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] tx_byte, [8] send_nack, [9] sda_in, rest zero
    input  logic [2:0]  s_tuser,   // [2:0] func

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] scl_level, [1] sda_level, [2] busy_res,
                                   // [3] done_res, [4] nack_seen, [12:5] rx_byte, rest zero

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // phase_ticks
);

    localparam int unsigned TW = i2cbm_pkg::TICK_W;

    // unpack the input word
    logic [7:0] in_tx_byte;
    logic       in_send_nack;
    logic       in_sda;
    logic [2:0] in_func;

    assign in_tx_byte   = s_tdata[7:0];
    assign in_send_nack = s_tdata[8];
    assign in_sda       = s_tdata[9];
    assign in_func      = s_tuser;

    // configuration
    logic [TW-1:0] phase_ticks_reg;

    // command state
    i2cbm_pkg::cmd_t cmd_reg, cmd_next;
    logic [1:0]      phase_reg, phase_next;
    logic [3:0]      bit_reg, bit_next;
    logic [7:0]      shift_reg, shift_next;
    logic [TW-1:0]   tick_reg, tick_next;
    logic            scl_reg, scl_next;
    logic            sda_reg, sda_next;
    logic            nack_reg, nack_next;
    logic            ack_reg, ack_next;
    logic [7:0]      tx_reg, tx_next;

    // result register
    logic        m_tvalid_reg;
    logic [15:0] m_tdata_reg;

    logic          accept;
    logic          done;
    logic [TW-1:0] limit;
    logic [TW-1:0] tick_inc;
    logic          finished;
    i2cbm_pkg::lines_t lines;

    // take a new word whenever the result register is empty or being drained
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign limit    = (phase_ticks_reg == '0) ? TW'(1) : phase_ticks_reg;
    assign tick_inc = tick_reg + TW'(1);

    // bus levels for a given point of a command
    function automatic i2cbm_pkg::lines_t levels(
        input i2cbm_pkg::cmd_t cmd,
        input logic [1:0]      ph,
        input logic [3:0]      bc,
        input logic [7:0]      tx,
        input logic            ack,
        input i2cbm_pkg::lines_t cur
    );
        i2cbm_pkg::lines_t l;
        l = cur;
        case (cmd)
            i2cbm_pkg::CMD_START: begin
                l.sda = (ph == i2cbm_pkg::PHASE_SETUP);
                l.scl = (ph != i2cbm_pkg::PHASE_HOLD);
            end
            i2cbm_pkg::CMD_STOP: begin
                l.sda = (ph == i2cbm_pkg::PHASE_HOLD);
                l.scl = (ph != i2cbm_pkg::PHASE_SETUP);
            end
            i2cbm_pkg::CMD_WRITE: begin
                l.sda = (bc < i2cbm_pkg::BIT_ACK) ? tx[3'(3'd7 - bc[2:0])] : 1'b1;
                l.scl = (ph == i2cbm_pkg::PHASE_SAMPLE);
            end
            i2cbm_pkg::CMD_READ: begin
                l.sda = (bc < i2cbm_pkg::BIT_ACK) ? 1'b1 : ack;
                l.scl = (ph == i2cbm_pkg::PHASE_SAMPLE);
            end
            default: begin
                l = cur;
            end
        endcase
        return l;
    endfunction

    always_comb begin
        cmd_next   = cmd_reg;
        phase_next = phase_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        tick_next  = tick_reg;
        nack_next  = nack_reg;
        ack_next   = ack_reg;
        tx_next    = tx_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        done       = 1'b0;
        finished   = 1'b0;
        lines      = '{scl: scl_reg, sda: sda_reg};

        if (cmd_reg == i2cbm_pkg::CMD_NONE) begin
            // idle: launch a known command, drop anything else
            if (in_func inside {[i2cbm_pkg::CMD_START : i2cbm_pkg::CMD_READ]}) begin
                cmd_next   = i2cbm_pkg::cmd_t'(in_func);
                phase_next = i2cbm_pkg::PHASE_SETUP;
                bit_next   = '0;
                tick_next  = '0;
                if (cmd_next == i2cbm_pkg::CMD_WRITE) begin
                    tx_next   = in_tx_byte;
                    nack_next = 1'b0;
                end else if (cmd_next == i2cbm_pkg::CMD_READ) begin
                    shift_next = '0;
                    ack_next   = in_send_nack;
                end
                lines    = levels(cmd_next, phase_next, bit_next, tx_next, ack_next, lines);
                scl_next = lines.scl;
                sda_next = lines.sda;
            end
        end else begin
            tick_next = tick_inc;
            if (tick_inc >= limit) begin
                // close the phase: sample on the SCL-high phase, then advance
                if (phase_reg == i2cbm_pkg::PHASE_SAMPLE) begin
                    if (cmd_reg == i2cbm_pkg::CMD_WRITE && bit_reg == i2cbm_pkg::BIT_ACK) begin
                        nack_next = in_sda;
                    end else if (cmd_reg == i2cbm_pkg::CMD_READ &&
                                 bit_reg < i2cbm_pkg::BIT_ACK) begin
                        shift_next = {shift_reg[6:0], in_sda};
                    end
                end
                tick_next = '0;
                if (phase_reg == i2cbm_pkg::PHASE_HOLD) begin
                    phase_next = i2cbm_pkg::PHASE_SETUP;
                    if (cmd_reg == i2cbm_pkg::CMD_WRITE || cmd_reg == i2cbm_pkg::CMD_READ) begin
                        bit_next = bit_reg + 4'd1;
                        finished = (bit_reg == i2cbm_pkg::BIT_ACK);
                    end else begin
                        finished = 1'b1;
                    end
                end else begin
                    phase_next = phase_reg + 2'd1;
                end

                if (finished) begin
                    // release SDA after a read's ACK bit; other lines hold
                    if (cmd_reg == i2cbm_pkg::CMD_READ) begin
                        sda_next = 1'b1;
                    end
                    cmd_next   = i2cbm_pkg::CMD_NONE;
                    phase_next = i2cbm_pkg::PHASE_SETUP;
                    bit_next   = '0;
                    done       = 1'b1;
                end else begin
                    lines    = levels(cmd_reg, phase_next, bit_next, tx_reg, ack_reg, lines);
                    scl_next = lines.scl;
                    sda_next = lines.sda;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg <= i2cbm_pkg::PHASE_TICKS_RESET;
            cmd_reg         <= i2cbm_pkg::CMD_NONE;
            phase_reg       <= '0;
            bit_reg         <= '0;
            shift_reg       <= '0;
            tick_reg        <= '0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            nack_reg        <= 1'b0;
            ack_reg         <= 1'b0;
            tx_reg          <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                phase_ticks_reg <= cfg_data;
            end
            if (accept) begin
                cmd_reg      <= cmd_next;
                phase_reg    <= phase_next;
                bit_reg      <= bit_next;
                shift_reg    <= shift_next;
                tick_reg     <= tick_next;
                scl_reg      <= scl_next;
                sda_reg      <= sda_next;
                nack_reg     <= nack_next;
                ack_reg      <= ack_next;
                tx_reg       <= tx_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // result word payload, loaded with the tick that produced it
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {3'b000, shift_next, nack_next, done,
                            (cmd_next != i2cbm_pkg::CMD_NONE), sda_next, scl_next};
        end
    end

    // the phase timer never reaches its limit while a command runs
    a_tick_below_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_reg != i2cbm_pkg::CMD_NONE |-> tick_reg < limit)
        else $error("phase timer at or past its limit");

    // phase and bit counters stay in their ranges
    a_counters_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= i2cbm_pkg::PHASE_HOLD && bit_reg <= i2cbm_pkg::BIT_ACK)
        else $error("phase or bit counter out of range");

    // a finishing tick reports idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tdata_reg[3] |-> !m_tdata_reg[2])
        else $error("done reported while still busy");

    // a held result word stays put while the sink stalls
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tready |=> m_tvalid_reg && $stable(m_tdata_reg))
        else $error("stalled result word changed");

    // an idle tick with a known command makes the block busy
    a_launch: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && cmd_reg == i2cbm_pkg::CMD_NONE && in_func != i2cbm_pkg::CMD_NONE &&
        in_func <= i2cbm_pkg::CMD_READ
        |=> cmd_reg != i2cbm_pkg::CMD_NONE && tick_reg == '0)
        else $error("command not launched");

endmodule

// ===== verif/i2cbm_line_checker.sv =====
`timescale 1ns / 100ps

// Watches the tick and line channels, models the bus engine tick by tick
// and checks every result word against the oldest prediction.
module i2cbm_line_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          open_count
);

    // same order as m_tdata[12:0]
    typedef struct packed {
        logic [7:0] rx;
        logic       nack;
        logic       done;
        logic       busy;
        logic       sda;
        logic       scl;
    } line_word_t;

    line_word_t line_q[$];

    i2cbm_pkg::cmd_t bus_cmd;
    logic [1:0]  phase;
    logic [3:0]  bit_idx;
    logic [7:0]  rx_shift;
    logic [15:0] tick_cnt;
    logic        scl_q;
    logic        sda_q;
    logic        nack_q;
    logic        nack_choice;
    logic [7:0]  tx_byte_q;
    logic [15:0] phase_len;

    function void drive_lines();
        case (bus_cmd)
            i2cbm_pkg::CMD_START: begin
                sda_q = (phase == i2cbm_pkg::PHASE_SETUP);
                scl_q = (phase != i2cbm_pkg::PHASE_HOLD);
            end
            i2cbm_pkg::CMD_STOP: begin
                sda_q = (phase == i2cbm_pkg::PHASE_HOLD);
                scl_q = (phase != i2cbm_pkg::PHASE_SETUP);
            end
            i2cbm_pkg::CMD_WRITE: begin
                sda_q = (bit_idx < i2cbm_pkg::BIT_ACK) ?
                        tx_byte_q[3'd7 - bit_idx[2:0]] : 1'b1;
                scl_q = (phase == i2cbm_pkg::PHASE_SAMPLE);
            end
            i2cbm_pkg::CMD_READ: begin
                sda_q = (bit_idx < i2cbm_pkg::BIT_ACK) ? 1'b1 : nack_choice;
                scl_q = (phase == i2cbm_pkg::PHASE_SAMPLE);
            end
            default: ;
        endcase
    endfunction

    // close the running phase; returns 1 when the command has finished
    function logic close_phase(input logic sda_in);
        logic byte_cmd;
        logic finished;
        byte_cmd = (bus_cmd == i2cbm_pkg::CMD_WRITE) || (bus_cmd == i2cbm_pkg::CMD_READ);
        finished = 1'b0;
        if (byte_cmd && phase == i2cbm_pkg::PHASE_SAMPLE) begin
            if (bus_cmd == i2cbm_pkg::CMD_WRITE && bit_idx == i2cbm_pkg::BIT_ACK)
                nack_q = sda_in;
            else if (bus_cmd == i2cbm_pkg::CMD_READ && bit_idx < i2cbm_pkg::BIT_ACK)
                rx_shift = {rx_shift[6:0], sda_in};
        end
        tick_cnt = '0;
        if (phase == i2cbm_pkg::PHASE_HOLD) begin
            phase = i2cbm_pkg::PHASE_SETUP;
            if (byte_cmd) begin
                bit_idx = bit_idx + 4'd1;
                finished = (bit_idx > i2cbm_pkg::BIT_ACK);
            end else begin
                finished = 1'b1;
            end
        end else begin
            phase = phase + 2'd1;
        end
        if (finished) begin
            if (bus_cmd == i2cbm_pkg::CMD_READ)
                sda_q = 1'b1;
            bus_cmd = i2cbm_pkg::CMD_NONE;
            phase = i2cbm_pkg::PHASE_SETUP;
            bit_idx = '0;
        end else begin
            drive_lines();
        end
        return finished;
    endfunction

    function line_word_t step_tick(input logic [2:0] func, input logic [7:0] txb,
                                   input logic nak, input logic sda_in);
        line_word_t  w;
        logic [15:0] limit;
        logic        done;
        limit = (phase_len == '0) ? 16'd1 : phase_len;
        done = 1'b0;
        if (bus_cmd == i2cbm_pkg::CMD_NONE) begin
            if (func >= i2cbm_pkg::CMD_START && func <= i2cbm_pkg::CMD_READ) begin
                bus_cmd = i2cbm_pkg::cmd_t'(func);
                phase = i2cbm_pkg::PHASE_SETUP;
                bit_idx = '0;
                tick_cnt = '0;
                if (func == i2cbm_pkg::CMD_WRITE) begin
                    tx_byte_q = txb;
                    nack_q = 1'b0;
                end else if (func == i2cbm_pkg::CMD_READ) begin
                    rx_shift = '0;
                    nack_choice = nak;
                end
                drive_lines();
            end
        end else begin
            tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt >= limit)
                done = close_phase(sda_in);
        end
        w.scl  = scl_q;
        w.sda  = sda_q;
        w.busy = (bus_cmd != i2cbm_pkg::CMD_NONE);
        w.done = done;
        w.nack = nack_q;
        w.rx   = rx_shift;
        return w;
    endfunction

    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v) begin
            fail_count++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want_v, got_v);
        end
    endtask

    always @(posedge aclk) begin
        line_word_t want;
        line_word_t got;
        if (!aresetn) begin
            bus_cmd = i2cbm_pkg::CMD_NONE;
            phase = i2cbm_pkg::PHASE_SETUP;
            bit_idx = '0;
            rx_shift = '0;
            tick_cnt = '0;
            scl_q = 1'b1;
            sda_q = 1'b1;
            nack_q = 1'b0;
            nack_choice = 1'b0;
            tx_byte_q = '0;
            phase_len = i2cbm_pkg::PHASE_TICKS_RESET;
            line_q.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                phase_len = cfg_data;
            if (s_tvalid && s_tready)
                line_q.push_back(step_tick(s_tuser, s_tdata[7:0], s_tdata[8], s_tdata[9]));
            if (m_tvalid && m_tready) begin
                got = m_tdata[12:0];
                if (line_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: no word expected, got %0h", $time, got);
                end else begin
                    want = line_q.pop_front();
                    check_field("scl_level", want.scl, got.scl);
                    check_field("sda_level", want.sda, got.sda);
                    check_field("busy", want.busy, got.busy);
                    check_field("done", want.done, got.done);
                    check_field("nack_seen", want.nack, got.nack);
                    check_field("rx_byte", want.rx, got.rx);
                end
            end
        end
        open_count = line_q.size();
    end

endmodule

// ===== verif/i2c_byte_master_test.sv =====
`timescale 1ns / 100ps

module i2c_byte_master_test;

    // phases a command spends on the bus: START/STOP three, a byte nine bits of three
    localparam int PHASES_EDGE = 3;
    localparam int PHASES_BYTE = 27;
    // func codes above the command range; the block must treat them as no command
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam int RANDOM_TICKS = 560;
    localparam int LONG_HOLD = 300;
    localparam int DRAIN_CYCLES = 8;

    typedef enum int {SDA_RANDOM, SDA_LOW, SDA_HIGH} sda_pattern_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata = '0;
    logic [2:0]  s_tuser = i2cbm_pkg::CMD_NONE;
    logic        m_tready = 1'b1;
    logic        cfg_valid = 1'b0;
    logic [15:0] cfg_data = '0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [15:0] m_tdata;
    wire         cfg_ready;
    int          fail_count;
    int          open_count;

    bit           src_jitter = 1'b0;    // random gaps on the tick stream
    bit           sink_jitter = 1'b0;   // random back-pressure on the line stream
    bit           sink_hold_req = 1'b0; // ask the sink for one long hold-off
    int           hold_left = 0;
    int           ticks_left = 0;       // ticks until the running command finishes
    int           phase_len_eff = i2cbm_pkg::PHASE_TICKS_RESET;
    int           sent_ticks = 0;
    sda_pattern_t sda_mode = SDA_RANDOM;

    i2c_byte_master dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    i2cbm_line_checker checker_i (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .fail_count(fail_count),
        .open_count(open_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Bail out if the run hangs: the slowest legal run is well under a tenth of this.
    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    // Line sink: one assignment to m_tready per falling edge. Short random
    // stalls, plus one long hold-off on request.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                hold_left = LONG_HOLD;
                m_tready <= 1'b0;
            end else if (sink_jitter && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(0, 3);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function logic next_sda();
        case (sda_mode)
            SDA_LOW:  return 1'b0;
            SDA_HIGH: return 1'b1;
            default:  return 1'($urandom_range(0, 1));
        endcase
    endfunction

    // Offer one tick word and hold it until the block takes it; track how long
    // the bus stays busy so commands and register writes land where intended.
    task automatic push_tick(input logic [2:0] func, input logic [7:0] txb, input logic nak);
        int gap;
        @(negedge aclk);
        if (src_jitter && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {6'd0, next_sda(), nak, txb};
        do @(posedge aclk); while (!s_tready);
        sent_ticks++;
        if (ticks_left > 0)
            ticks_left--;
        else if (func >= i2cbm_pkg::CMD_START && func <= i2cbm_pkg::CMD_READ)
            ticks_left = ((func == i2cbm_pkg::CMD_WRITE || func == i2cbm_pkg::CMD_READ) ?
                          PHASES_BYTE : PHASES_EDGE) * phase_len_eff;
    endtask

    // Issue a command on an idle bus and feed ticks until it has finished.
    // With noise on, some of those ticks carry commands the block must ignore.
    task automatic run_command(input logic [2:0] func, input logic [7:0] txb,
                               input logic nak, input bit noisy);
        push_tick(func, txb, nak);
        while (ticks_left > 0) begin
            if (noisy && $urandom_range(0, 9) == 0)
                push_tick(3'($urandom_range(i2cbm_pkg::CMD_START, CMD_SPARE_HI)),
                          8'($urandom), 1'($urandom));
            else
                push_tick(i2cbm_pkg::CMD_NONE, 8'($urandom), 1'($urandom));
        end
    endtask

    // Change the phase length only with the bus idle and every line word back.
    task automatic set_phase_len(input logic [15:0] len);
        while (ticks_left > 0)
            push_tick(i2cbm_pkg::CMD_NONE, 8'($urandom), 1'($urandom));
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (open_count != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        phase_len_eff = (len == '0) ? 1 : len;
    endtask

    // Mostly whole transfers with random content; the rest lone commands,
    // spare codes and idle ticks.
    task automatic random_bus(input int stop_at);
        int pick;
        int n_bytes;
        while (sent_ticks < stop_at) begin
            pick = $urandom_range(0, 99);
            sda_mode = sda_pattern_t'($urandom_range(0, 4) < 3 ? SDA_RANDOM
                                      : $urandom_range(SDA_LOW, SDA_HIGH));
            if (pick < 70) begin
                run_command(i2cbm_pkg::CMD_START, 8'($urandom), 1'($urandom), 1'b1);
                run_command(i2cbm_pkg::CMD_WRITE, 8'($urandom), 1'($urandom), 1'b1);
                n_bytes = $urandom_range(0, 3);
                repeat (n_bytes) begin
                    if ($urandom_range(0, 1))
                        run_command(i2cbm_pkg::CMD_READ, 8'($urandom), 1'($urandom), 1'b1);
                    else
                        run_command(i2cbm_pkg::CMD_WRITE, 8'($urandom), 1'($urandom), 1'b1);
                end
                // repeated start now and then, otherwise a clean stop
                if ($urandom_range(0, 4) == 0)
                    run_command(i2cbm_pkg::CMD_START, 8'($urandom), 1'($urandom), 1'b0);
                else
                    run_command(i2cbm_pkg::CMD_STOP, 8'($urandom), 1'($urandom), 1'b0);
            end else if (pick < 85) begin
                run_command(3'($urandom_range(i2cbm_pkg::CMD_START, i2cbm_pkg::CMD_READ)),
                            8'($urandom), 1'($urandom), 1'b1);
            end else begin
                repeat ($urandom_range(1, 5)) begin
                    if ($urandom_range(0, 1))
                        push_tick(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)),
                                  8'($urandom), 1'($urandom));
                    else
                        push_tick(i2cbm_pkg::CMD_NONE, 8'($urandom), 1'($urandom));
                end
            end
        end
    endtask

    initial begin
        logic [15:0] phase_plan[6];
        int          share;
        phase_plan = '{16'd3, 16'd1, 16'd2, 16'd0, 16'd4, 16'd1};

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        src_jitter  = 1'b1;
        sink_jitter = 1'b1;

        // Reset phase length: plain start and stop, a command thrown at a busy
        // bus, and the spare func codes on an idle bus.
        run_command(i2cbm_pkg::CMD_START, 8'h00, 1'b0, 1'b0);
        run_command(i2cbm_pkg::CMD_STOP, 8'hFF, 1'b1, 1'b0);
        push_tick(i2cbm_pkg::CMD_START, 8'h00, 1'b0);
        push_tick(i2cbm_pkg::CMD_WRITE, 8'hA5, 1'b1);
        run_command(i2cbm_pkg::CMD_NONE, 8'h00, 1'b0, 1'b0);
        for (int code = CMD_SPARE_LO; code <= CMD_SPARE_HI; code++)
            push_tick(3'(code), 8'($urandom), 1'($urandom));

        // Shortest phases: byte extremes against a slave that acks, one that
        // never answers, and reads of all-low and all-high lines with ACK and NACK.
        set_phase_len(16'd1);
        run_command(i2cbm_pkg::CMD_START, 8'h00, 1'b0, 1'b0);
        sda_mode = SDA_LOW;
        run_command(i2cbm_pkg::CMD_WRITE, 8'h00, 1'b0, 1'b0);
        sda_mode = SDA_HIGH;
        run_command(i2cbm_pkg::CMD_WRITE, 8'hFF, 1'b1, 1'b0);
        sda_mode = SDA_RANDOM;
        run_command(i2cbm_pkg::CMD_WRITE, 8'h5A, 1'b0, 1'b0);
        sda_mode = SDA_HIGH;
        run_command(i2cbm_pkg::CMD_READ, 8'h00, 1'b0, 1'b0);
        sda_mode = SDA_LOW;
        run_command(i2cbm_pkg::CMD_READ, 8'hFF, 1'b1, 1'b0);
        sda_mode = SDA_RANDOM;
        run_command(i2cbm_pkg::CMD_READ, 8'h3C, 1'b1, 1'b0);
        run_command(i2cbm_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0);

        // A zero phase length must behave as one.
        set_phase_len(16'd0);
        run_command(i2cbm_pkg::CMD_START, 8'h00, 1'b0, 1'b0);
        run_command(i2cbm_pkg::CMD_WRITE, 8'hC3, 1'b0, 1'b0);
        run_command(i2cbm_pkg::CMD_READ, 8'h00, 1'b0, 1'b0);
        run_command(i2cbm_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0);

        // Random traffic over several phase lengths; in the third one stall the
        // sink for a long stretch so the block backs up onto its input.
        share = RANDOM_TICKS / $size(phase_plan);
        foreach (phase_plan[k]) begin
            set_phase_len(phase_plan[k]);
            if (k == 2)
                sink_hold_req = 1'b1;
            random_bus(sent_ticks + share);
        end

        // Last part, no idling: a long phase length over one START, then
        // back to short phases for a final burst.
        src_jitter  = 1'b0;
        sink_jitter = 1'b0;
        set_phase_len(16'd40);
        run_command(i2cbm_pkg::CMD_START, 8'($urandom), 1'($urandom), 1'b0);
        set_phase_len(16'd1);
        random_bus(sent_ticks + 200);

        // Drop valid, wait for every line word, then let the pipeline settle.
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (open_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== i2c_byte_master.f =====
src/i2cbm_pkg.sv
src/i2c_byte_master.sv
verif/i2cbm_line_checker.sv
verif/i2c_byte_master_test.sv
